@@ sv/assert_macros.svh @@
// assertion macros shared by the circle core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CFTP_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("circle core: implication violated");

// condition that must never be seen outside reset
`define CFTP_ASSERT_NEVER(lbl, a) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(a)) \
		else $error("circle core: forbidden condition seen");

`endif

@@ sv/cftp_pkg.sv @@
// widths and types shared by the circle-through-three-points pipeline
package cftp_pkg;

	localparam int CW  = 16;              // coordinate width
	localparam int DW  = CW + 1;          // coordinate difference
	localparam int SQW = 2 * CW;          // coordinate square
	localparam int BW  = 2 * CW + 1;      // difference of squared norms
	localparam int PW  = 2 * DW;          // determinant partial product
	localparam int ETW = PW + 1;          // determinant
	localparam int MW  = BW + DW;         // numerator partial product
	localparam int NW  = MW + 1;          // numerator
	localparam int QW  = NW;              // quotient magnitude
	localparam int VW  = ETW + 1;         // divisor magnitude, 2*|det|
	localparam int UW  = (QW + 2 > 33) ? QW + 2 : 33; // distance to second point
	localparam int OW  = 32;              // output width
	localparam int SW  = 2 * OW;          // squared radius
	localparam int RW  = OW + 4;          // square root remainder

	localparam logic signed [OW-1:0] OMAX = {1'b0, {(OW-1){1'b1}}};
	localparam logic signed [OW-1:0] OMIN = {1'b1, {(OW-1){1'b0}}};

	typedef struct packed {
		logic                 zero;
		logic                 qx_neg;
		logic                 qy_neg;
		logic signed [CW-1:0] x2;
		logic signed [CW-1:0] y2;
	} div_tag_t;

	typedef struct packed {
		logic                 collinear;
		logic                 covf;
		logic                 rad_sat;
		logic signed [OW-1:0] cx;
		logic signed [OW-1:0] cy;
	} sq_tag_t;

endpackage

@@ sv/circle_from_three_points_core.sv @@
// circle through three points: top level with center fixup and output register
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------
//  input    | start, busy      | point1_x/y, point2_x/y, point3_x/y
//  result   | done (strobe)    | center_x, center_y, radius, collinear, overflow
//
// one transaction is taken every cycle; busy stays low
// the pipeline depth is set mostly by the one-bit-per-stage center divider
// (QW+1 stages) and the 33-stage square root
// reset clears only the valid bits; results in flight are dropped
// the receiver takes done as it comes, so nothing in the pipeline ever waits
`include "assert_macros.svh"

module circle_from_three_points_core import cftp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [CW-1:0] point1_x,
	input  logic signed [CW-1:0] point1_y,
	input  logic signed [CW-1:0] point2_x,
	input  logic signed [CW-1:0] point2_y,
	input  logic signed [CW-1:0] point3_x,
	input  logic signed [CW-1:0] point3_y,
	output logic                 done,
	output logic signed [OW-1:0] center_x,
	output logic signed [OW-1:0] center_y,
	output logic [OW-1:0]        radius,
	output logic                 collinear,
	output logic                 overflow
);

	localparam int LAT = QW + 43;

	logic                  fv;
	logic signed [NW-1:0]  fnx, fny;
	logic signed [ETW-1:0] fdet;
	logic signed [CW-1:0]  fx2, fy2;
	logic                  dv;
	div_tag_t              dtag;
	logic [QW-1:0]         qx, qy;

	logic                  v_s6, v_s7, v_s8, v_s9;
	div_tag_t              tag_s6;
	logic signed [QW:0]    cx_s6, cy_s6;
	logic                  zero_s7, zero_s8;
	logic signed [UW-1:0]  dx_s7, dy_s7;
	logic signed [OW-1:0]  ocx_s7, ocy_s7, ocx_s8, ocy_s8;
	logic                  covf_s7, covf_s8;
	logic [OW-1:0]         uxlo_s8, uylo_s8;
	logic                  big_s8;
	sq_tag_t               tag_s9;
	logic [SW-1:0]         sqx_s9, sqy_s9;

	logic                  sv;
	sq_tag_t               stag;
	logic [OW-1:0]         root;

	logic                  xhi, xlo, yhi, ylo;
	logic [UW-1:0]         ux, uy;

	logic                  done_q, col_q, ovf_q;
	logic signed [OW-1:0]  cx_q, cy_q;
	logic [OW-1:0]         rad_q;

	assign busy = 1'b0;

	cftp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.v_i    (start),
		.p1x    (point1_x),
		.p1y    (point1_y),
		.p2x    (point2_x),
		.p2y    (point2_y),
		.p3x    (point3_x),
		.p3y    (point3_y),
		.v_o    (fv),
		.nx_o   (fnx),
		.ny_o   (fny),
		.det_o  (fdet),
		.x2_o   (fx2),
		.y2_o   (fy2)
	);

	cftp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.v_i    (fv),
		.nx_i   (fnx),
		.ny_i   (fny),
		.det_i  (fdet),
		.x2_i   (fx2),
		.y2_i   (fy2),
		.v_o    (dv),
		.tag_o  (dtag),
		.qx_o   (qx),
		.qy_o   (qy)
	);

	always_comb begin
		xhi = UW'(cx_s6) > UW'(OMAX);
		xlo = UW'(cx_s6) < UW'(OMIN);
		yhi = UW'(cy_s6) > UW'(OMAX);
		ylo = UW'(cy_s6) < UW'(OMIN);
		ux  = dx_s7[UW-1] ? $unsigned(-dx_s7) : $unsigned(dx_s7);
		uy  = dy_s7[UW-1] ? $unsigned(-dy_s7) : $unsigned(dy_s7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s6 <= dv;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		// stage 6: signed centers
		tag_s6 <= dtag;
		cx_s6  <= dtag.qx_neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		cy_s6  <= dtag.qy_neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		// stage 7: offset to the second point, saturated centers
		zero_s7 <= tag_s6.zero;
		dx_s7   <= UW'(tag_s6.x2) - UW'(cx_s6);
		dy_s7   <= UW'(tag_s6.y2) - UW'(cy_s6);
		ocx_s7  <= xhi ? OMAX : (xlo ? OMIN : OW'(cx_s6));
		ocy_s7  <= yhi ? OMAX : (ylo ? OMIN : OW'(cy_s6));
		covf_s7 <= xhi | xlo | yhi | ylo;
		// stage 8: magnitudes, anything past 32 bits saturates the radius
		zero_s8 <= zero_s7;
		ocx_s8  <= ocx_s7;
		ocy_s8  <= ocy_s7;
		covf_s8 <= covf_s7;
		uxlo_s8 <= ux[OW-1:0];
		uylo_s8 <= uy[OW-1:0];
		big_s8  <= (|ux[UW-1:OW]) | (|uy[UW-1:OW]);
		// stage 9: squares
		sqx_s9            <= SW'(uxlo_s8) * SW'(uxlo_s8);
		sqy_s9            <= SW'(uylo_s8) * SW'(uylo_s8);
		tag_s9.collinear  <= zero_s8;
		tag_s9.covf       <= covf_s8;
		tag_s9.rad_sat    <= big_s8;
		tag_s9.cx         <= ocx_s8;
		tag_s9.cy         <= ocy_s8;
	end

	cftp_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.v_i    (v_s9),
		.tag_i  (tag_s9),
		.sqx_i  (sqx_s9),
		.sqy_i  (sqy_s9),
		.v_o    (sv),
		.tag_o  (stag),
		.root_o (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sv;
		end
	end

	always_ff @(posedge clk) begin
		col_q <= stag.collinear;
		if (stag.collinear) begin
			cx_q  <= '0;
			cy_q  <= '0;
			rad_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			cx_q  <= stag.cx;
			cy_q  <= stag.cy;
			rad_q <= stag.rad_sat ? '1 : root;
			ovf_q <= stag.covf | stag.rad_sat;
		end
	end

	assign done      = done_q;
	assign center_x  = cx_q;
	assign center_y  = cy_q;
	assign radius    = rad_q;
	assign collinear = col_q;
	assign overflow  = ovf_q;

	`CFTP_ASSERT_IMP(a_latency, done, $past(start, LAT))
	`CFTP_ASSERT_IMP(a_colin_zero, done && collinear,
		center_x == '0 && center_y == '0 && radius == '0)
	`CFTP_ASSERT_NEVER(a_colin_ovf, done && collinear && overflow)

endmodule

@@ sv/cftp_front.sv @@
// front stages: differences, squares, determinant and center numerators
module cftp_front import cftp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 v_i,
	input  logic signed [CW-1:0] p1x,
	input  logic signed [CW-1:0] p1y,
	input  logic signed [CW-1:0] p2x,
	input  logic signed [CW-1:0] p2y,
	input  logic signed [CW-1:0] p3x,
	input  logic signed [CW-1:0] p3y,
	output logic                 v_o,
	output logic signed [NW-1:0] nx_o,
	output logic signed [NW-1:0] ny_o,
	output logic signed [ETW-1:0] det_o,
	output logic signed [CW-1:0] x2_o,
	output logic signed [CW-1:0] y2_o
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [DW-1:0] dx12_s1, dx23_s1, dy12_s1, dy23_s1;
	logic signed [SQW-1:0] sx1_s1, sy1_s1, sx2_s1, sy2_s1, sx3_s1, sy3_s1;
	logic signed [CW-1:0] x2_s1, y2_s1, x2_s2, y2_s2, x2_s3, y2_s3, x2_s4, y2_s4;
	logic signed [DW-1:0] dx12_s2, dx23_s2, dy12_s2, dy23_s2;
	logic signed [BW-1:0] bc_s2, cd_s2;
	logic signed [PW-1:0] pa_s2, pb_s2;
	logic signed [ETW-1:0] det_s3, det_s4;
	logic signed [MW-1:0] m1_s3, m2_s3, m3_s3, m4_s3;
	logic signed [NW-1:0] nx_s4, ny_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: differences and squares
		dx12_s1 <= {p1x[CW-1], p1x} - {p2x[CW-1], p2x};
		dx23_s1 <= {p2x[CW-1], p2x} - {p3x[CW-1], p3x};
		dy12_s1 <= {p1y[CW-1], p1y} - {p2y[CW-1], p2y};
		dy23_s1 <= {p2y[CW-1], p2y} - {p3y[CW-1], p3y};
		sx1_s1  <= SQW'(p1x) * SQW'(p1x);
		sy1_s1  <= SQW'(p1y) * SQW'(p1y);
		sx2_s1  <= SQW'(p2x) * SQW'(p2x);
		sy2_s1  <= SQW'(p2y) * SQW'(p2y);
		sx3_s1  <= SQW'(p3x) * SQW'(p3x);
		sy3_s1  <= SQW'(p3y) * SQW'(p3y);
		x2_s1   <= p2x;
		y2_s1   <= p2y;
		// stage 2: norm differences and determinant products
		bc_s2   <= BW'(sx1_s1) + BW'(sy1_s1) - BW'(sx2_s1) - BW'(sy2_s1);
		cd_s2   <= BW'(sx2_s1) + BW'(sy2_s1) - BW'(sx3_s1) - BW'(sy3_s1);
		pa_s2   <= PW'(dx12_s1) * PW'(dy23_s1);
		pb_s2   <= PW'(dx23_s1) * PW'(dy12_s1);
		dx12_s2 <= dx12_s1;
		dx23_s2 <= dx23_s1;
		dy12_s2 <= dy12_s1;
		dy23_s2 <= dy23_s1;
		x2_s2   <= x2_s1;
		y2_s2   <= y2_s1;
		// stage 3: determinant and numerator products
		det_s3  <= ETW'(pa_s2) - ETW'(pb_s2);
		m1_s3   <= MW'(bc_s2) * MW'(dy23_s2);
		m2_s3   <= MW'(cd_s2) * MW'(dy12_s2);
		m3_s3   <= MW'(cd_s2) * MW'(dx12_s2);
		m4_s3   <= MW'(bc_s2) * MW'(dx23_s2);
		x2_s3   <= x2_s2;
		y2_s3   <= y2_s2;
		// stage 4: numerators
		nx_s4   <= NW'(m1_s3) - NW'(m2_s3);
		ny_s4   <= NW'(m3_s3) - NW'(m4_s3);
		det_s4  <= det_s3;
		x2_s4   <= x2_s3;
		y2_s4   <= y2_s3;
	end

	assign v_o   = v_s4;
	assign nx_o  = nx_s4;
	assign ny_o  = ny_s4;
	assign det_o = det_s4;
	assign x2_o  = x2_s4;
	assign y2_o  = y2_s4;

endmodule

@@ sv/cftp_div.sv @@
// pipelined restoring divider, one quotient bit per stage, both centers share the divisor
module cftp_div import cftp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  v_i,
	input  logic signed [NW-1:0]  nx_i,
	input  logic signed [NW-1:0]  ny_i,
	input  logic signed [ETW-1:0] det_i,
	input  logic signed [CW-1:0]  x2_i,
	input  logic signed [CW-1:0]  y2_i,
	output logic                  v_o,
	output div_tag_t              tag_o,
	output logic [QW-1:0]         qx_o,
	output logic [QW-1:0]         qy_o
);

	logic           v_s   [QW+1];
	div_tag_t       tag_s [QW+1];
	logic [QW-1:0]  ax_s  [QW+1];
	logic [QW-1:0]  ay_s  [QW+1];
	logic [VW-1:0]  rx_s  [QW+1];
	logic [VW-1:0]  ry_s  [QW+1];
	logic [VW-1:0]  den_s [QW+1];

	// stage 0: magnitudes and signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		tag_s[0].zero   <= (det_i == '0);
		tag_s[0].qx_neg <= nx_i[NW-1] ^ det_i[ETW-1];
		tag_s[0].qy_neg <= ny_i[NW-1] ^ det_i[ETW-1];
		tag_s[0].x2     <= x2_i;
		tag_s[0].y2     <= y2_i;
		ax_s[0]  <= nx_i[NW-1] ? $unsigned(-nx_i) : $unsigned(nx_i);
		ay_s[0]  <= ny_i[NW-1] ? $unsigned(-ny_i) : $unsigned(ny_i);
		den_s[0] <= {(det_i[ETW-1] ? $unsigned(-det_i) : $unsigned(det_i)), 1'b0};
		rx_s[0]  <= '0;
		ry_s[0]  <= '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [VW:0]   tx, ty;
		logic          gx, gy;
		logic [VW-1:0] nrx, nry;

		// the dividend register fills with quotient bits from the bottom
		always_comb begin
			tx  = {rx_s[k], ax_s[k][QW-1]};
			ty  = {ry_s[k], ay_s[k][QW-1]};
			gx  = tx >= {1'b0, den_s[k]};
			gy  = ty >= {1'b0, den_s[k]};
			nrx = gx ? VW'(tx - {1'b0, den_s[k]}) : tx[VW-1:0];
			nry = gy ? VW'(ty - {1'b0, den_s[k]}) : ty[VW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			tag_s[k+1] <= tag_s[k];
			ax_s[k+1]  <= {ax_s[k][QW-2:0], gx};
			ay_s[k+1]  <= {ay_s[k][QW-2:0], gy};
			rx_s[k+1]  <= nrx;
			ry_s[k+1]  <= nry;
			den_s[k+1] <= den_s[k];
		end
	end

	assign v_o   = v_s[QW];
	assign tag_o = tag_s[QW];
	assign qx_o  = ax_s[QW];
	assign qy_o  = ay_s[QW];

endmodule

@@ sv/cftp_sqrt.sv @@
// pipelined floor square root, two radicand bits per stage
module cftp_sqrt import cftp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_i,
	input  sq_tag_t       tag_i,
	input  logic [SW-1:0] sqx_i,
	input  logic [SW-1:0] sqy_i,
	output logic          v_o,
	output sq_tag_t       tag_o,
	output logic [OW-1:0] root_o
);

	logic          v_s    [OW+1];
	sq_tag_t       tag_s  [OW+1];
	logic [SW-1:0] n_s    [OW+1];
	logic [RW-1:0] rem_s  [OW+1];
	logic [OW-1:0] root_s [OW+1];
	logic [SW:0]   sum;

	assign sum = {1'b0, sqx_i} + {1'b0, sqy_i};

	// stage 0: squared distance, carry out means the radius saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		tag_s[0]  <= '{collinear: tag_i.collinear, covf: tag_i.covf,
			rad_sat: tag_i.rad_sat | sum[SW], cx: tag_i.cx, cy: tag_i.cy};
		n_s[0]    <= sum[SW-1:0];
		rem_s[0]  <= '0;
		root_s[0] <= '0;
	end

	for (genvar k = 0; k < OW; k++) begin : g_stage
		logic [RW-1:0] t, trial;
		logic          g;

		always_comb begin
			t     = {rem_s[k][RW-3:0], n_s[k][SW-1:SW-2]};
			trial = RW'({root_s[k], 2'b01});
			g     = t >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			tag_s[k+1]  <= tag_s[k];
			n_s[k+1]    <= {n_s[k][SW-3:0], 2'b00};
			rem_s[k+1]  <= g ? t - trial : t;
			root_s[k+1] <= {root_s[k][OW-2:0], g};
		end
	end

	assign v_o    = v_s[OW];
	assign tag_o  = tag_s[OW];
	assign root_o = root_s[OW];

endmodule
